// ===== design/quaternion_arithmetic_unit_top_defines.svh =====
// Assertion macros for the quaternion arithmetic unit.
// Included by quaternion_arithmetic_unit_top; empty when SYNTHESIS is set.
`ifndef QUATERNION_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define QAU_ASSERT_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error("qau: forbidden condition seen");
`define QAU_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("qau: implication failed");
`define QAU_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("qau: next-cycle check failed");
`else
`define QAU_ASSERT_NEVER(lbl, ck, rs, expr)
`define QAU_ASSERT_IMPLIES(lbl, ck, rs, ante, cons)
`define QAU_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== design/qau_pkg.sv =====
// Shared types and helpers for the quaternion arithmetic unit.
// No dependencies.
package qau_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_PROD  = 4'd2,
    OP_SCALE = 4'd3,
    OP_CONJ  = 4'd4,
    OP_NORM  = 4'd5,
    OP_NORMZ = 4'd6,
    OP_CROSS = 4'd7,
    OP_DOT   = 4'd8
  } op_t;

  localparam int unsigned SQRT_STEPS = 32;

  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic [31:0] v;
    logic        ov;
  } sat_t;

  // item state carried through the sqrt and divide stages
  typedef struct packed {
    op_t              op;
    logic [3:0][31:0] r;
    logic [31:0]      sc;
    logic             ov;
    logic             dz;
    logic [63:0]      s;
    logic [63:0]      root;
    logic [32:0]      n;
    logic [3:0]       neg;
    logic [3:0][31:0] m;
    logic [3:0][63:0] rem;
    logic [3:0][31:0] q;
  } pipe_t;

  localparam wide_t MAX32 = 66'sd2147483647;
  localparam wide_t MIN32 = -66'sd2147483648;

  function automatic wide_t sx32(input logic [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic sat_t sat32(input wide_t x);
    sat_t res;
    res.v  = x[31:0];
    res.ov = 1'b0;
    if (x > MAX32) begin
      res.v  = 32'h7FFF_FFFF;
      res.ov = 1'b1;
    end else if (x < MIN32) begin
      res.v  = 32'h8000_0000;
      res.ov = 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== design/qau_intf.sv =====
// Valid/ready channel interfaces for the quaternion arithmetic unit.
// No dependencies.
interface qau_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [31:0] a_w;
  logic [31:0] a_x;
  logic [31:0] a_y;
  logic [31:0] a_z;
  logic [31:0] b_w;
  logic [31:0] b_x;
  logic [31:0] b_y;
  logic [31:0] b_z;
  logic [31:0] factor;
  modport source (output valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor,
                  input ready);
  modport sink (input valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor,
                output ready);
endinterface

interface qau_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] r_w;
  logic [31:0] r_x;
  logic [31:0] r_y;
  logic [31:0] r_z;
  logic [31:0] scalar_out;
  logic        overflow;
  logic        div_zero;
  modport source (output valid, r_w, r_x, r_y, r_z, scalar_out, overflow, div_zero,
                  input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, scalar_out, overflow, div_zero,
                output ready);
endinterface

// ===== design/qau_sqrt_step.sv =====
// One registered step of the digit-by-digit integer square root.
// Depends on qau_pkg.
module qau_sqrt_step #(
  parameter int unsigned K = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qau_pkg::pipe_t in_item,
  output logic          out_valid,
  output qau_pkg::pipe_t out_item
);
  import qau_pkg::*;

  localparam int unsigned SH  = 62 - 2 * K;
  localparam logic [63:0] BIT = 64'd1 << SH;

  pipe_t       nx;
  logic [64:0] trial;

  always_comb begin
    nx    = in_item;
    trial = {1'b0, in_item.root} + {1'b0, BIT};
    if ({1'b0, in_item.s} >= trial) begin
      nx.s    = in_item.s - trial[63:0];
      nx.root = (in_item.root >> 1) + BIT;
    end else begin
      nx.root = in_item.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= nx;
    end
  end

endmodule

// ===== design/qau_div_step.sv =====
// One registered restoring-division step: quotient bit K for all four lanes.
// Depends on qau_pkg.
module qau_div_step #(
  parameter int unsigned K = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qau_pkg::pipe_t in_item,
  output logic          out_valid,
  output qau_pkg::pipe_t out_item
);
  import qau_pkg::*;

  pipe_t       nx;
  logic [63:0] dsr;

  always_comb begin
    nx  = in_item;
    dsr = {31'b0, in_item.n} << K;
    for (int i = 0; i < 4; i++) begin
      if (in_item.rem[i] >= dsr) begin
        nx.rem[i]  = in_item.rem[i] - dsr;
        nx.q[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= nx;
    end
  end

endmodule

// ===== design/quaternion_arithmetic_unit_top.sv =====
// Quaternion arithmetic unit: pipelined fixed-point quaternion ALU.
// Depends on qau_pkg, qau_intf, qau_sqrt_step, qau_div_step and the defines header.
//
// Usage:
//   cmd carries one item per handshake: op, operands a and b, and factor.
//   res returns exactly one item per command, in order: r_w..r_z,
//   scalar_out, overflow and div_zero.
//   Every op takes the same path through all stages to res.valid.
//   Throughput is one item per cycle while res is not stalled. Depth is
//   set by the 32 square-root stages that the norm ops need and the
//   FRAC_BITS + 1 divide stages that the normalize op needs.
//   Front end: input register, 16 shared 32x32 multipliers, sum stage,
//   round/saturate stage.
//   When res is stalled the whole pipeline holds and cmd.ready drops;
//   nothing is lost or repeated, and cmd.ready returns as soon as
//   res.ready does.
//   Reset (synchronous, active high) clears all valid bits; no item is in
//   flight afterwards. There is no configuration.
`include "quaternion_arithmetic_unit_top_defines.svh"
module quaternion_arithmetic_unit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  qau_cmd_if.sink  cmd,
  qau_res_if.source res
);
  import qau_pkg::*;

  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam wide_t       HALF      = 66'sd1 <<< (FRAC_BITS - 1);

  logic en;
  assign en        = !res.valid || res.ready;
  assign cmd.ready = en;

  // ---------------- stage 1: input register ----------------
  logic [3:0][31:0] a_in, b_sel;
  logic             s1_vld;
  op_t              s1_op;
  logic [3:0][31:0] s1_a, s1_b;

  always_comb begin
    a_in = {cmd.a_z, cmd.a_y, cmd.a_x, cmd.a_w};
    case (op_t'(cmd.op))
      OP_SCALE:          b_sel = {4{cmd.factor}};
      OP_NORM, OP_NORMZ: b_sel = a_in;   // squares for the norm
      default:           b_sel = {cmd.b_z, cmd.b_y, cmd.b_x, cmd.b_w};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= op_t'(cmd.op);
      s1_a  <= a_in;
      s1_b  <= b_sel;
    end
  end

  // ---------------- stage 2: products, add/sub/conjugate ----------------
  logic [3:0][31:0]   simp_r;
  logic               simp_ov;
  logic               s2_vld;
  op_t                s2_op;
  logic [3:0][31:0]   s2_a, s2_r;
  logic               s2_ov;
  logic signed [63:0] s2_p [4][4];

  always_comb begin
    sat_t st;
    simp_ov = 1'b0;
    for (int i = 0; i < 4; i++) begin
      case (s1_op)
        OP_ADD: st = sat32(sx32(s1_a[i]) + sx32(s1_b[i]));
        OP_SUB: st = sat32(sx32(s1_a[i]) - sx32(s1_b[i]));
        OP_CONJ: begin
          if (i == 0) begin
            st.v  = s1_a[i];
            st.ov = 1'b0;
          end else begin
            st = sat32(-sx32(s1_a[i]));
          end
        end
        default: st = '0;
      endcase
      simp_r[i] = st.v;
      simp_ov   = simp_ov | st.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op <= s1_op;
      s2_a  <= s1_a;
      s2_r  <= simp_r;
      s2_ov <= simp_ov;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          s2_p[i][j] <= 64'(signed'(s1_a[i])) * 64'(signed'(s1_b[j]));
        end
      end
    end
  end

  // ---------------- stage 3: exact sums of products ----------------
  wide_t            e [4][4];
  wide_t            t_nx [4];
  logic             s3_vld;
  op_t              s3_op;
  logic [3:0][31:0] s3_a, s3_r;
  logic             s3_ov;
  wide_t            s3_t [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = wide_t'(s2_p[i][j]);
      end
      t_nx[i] = '0;
    end
    case (s2_op)
      OP_PROD: begin
        t_nx[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
        t_nx[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
        t_nx[2] = e[0][2] + e[2][0] + e[3][1] - e[1][3];
        t_nx[3] = e[0][3] + e[3][0] + e[1][2] - e[2][1];
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) t_nx[i] = e[i][i];
      end
      OP_CROSS: begin
        t_nx[1] = e[2][3] - e[3][2];
        t_nx[2] = e[3][1] - e[1][3];
        t_nx[3] = e[1][2] - e[2][1];
      end
      OP_DOT:            t_nx[0] = e[1][1] + e[2][2] + e[3][3];
      OP_NORM, OP_NORMZ: t_nx[0] = e[0][0] + e[1][1] + e[2][2] + e[3][3];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op <= s2_op;
      s3_a  <= s2_a;
      s3_r  <= s2_r;
      s3_ov <= s2_ov;
      for (int i = 0; i < 4; i++) s3_t[i] <= t_nx[i];
    end
  end

  // ---------------- stage 4: round, saturate, set up sqrt ----------------
  pipe_t                st4;
  logic [SQRT_STEPS:0]  sq_vld;
  pipe_t                sq [SQRT_STEPS+1];

  always_comb begin
    sat_t  rs [4];
    wide_t rnd;
    st4    = '0;
    st4.op = s3_op;
    for (int i = 0; i < 4; i++) begin
      rnd        = (s3_t[i] + HALF) >>> FRAC_BITS;
      rs[i]      = sat32(rnd);
      st4.neg[i] = s3_a[i][31];
      st4.m[i]   = s3_a[i][31] ? (~s3_a[i] + 32'd1) : s3_a[i];
    end
    case (s3_op)
      OP_ADD, OP_SUB, OP_CONJ: begin
        st4.r  = s3_r;
        st4.ov = s3_ov;
      end
      OP_PROD, OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 4; i++) begin
          st4.r[i] = rs[i].v;
          st4.ov   = st4.ov | rs[i].ov;
        end
      end
      OP_DOT: begin
        st4.sc = rs[0].v;
        st4.ov = rs[0].ov;
      end
      OP_NORM, OP_NORMZ: begin
        // a sum of 2^64 clips to all ones
        st4.s = s3_t[0][64] ? '1 : s3_t[0][63:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= st4;
    end
  end

  // ---------------- square root: one result bit per stage ----------------
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qau_sqrt_step #(.K(k)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_vld[k]),
      .in_item   (sq[k]),
      .out_valid (sq_vld[k+1]),
      .out_item  (sq[k+1])
    );
  end

  // ---------------- norm rounding, divide setup ----------------
  pipe_t                nr;
  logic [32:0]          n_rnd;
  logic [DIV_STEPS:0]   dv_vld;
  pipe_t                dv [DIV_STEPS+1];

  always_comb begin
    nr    = sq[SQRT_STEPS];
    n_rnd = (sq[SQRT_STEPS].s > sq[SQRT_STEPS].root) ?
            (sq[SQRT_STEPS].root[32:0] + 33'd1) : sq[SQRT_STEPS].root[32:0];
    nr.n  = n_rnd;
    nr.q  = '0;
    for (int i = 0; i < 4; i++) begin
      nr.rem[i] = ({32'b0, sq[SQRT_STEPS].m[i]} << FRAC_BITS) + {31'b0, n_rnd >> 1};
    end
    if (sq[SQRT_STEPS].op == OP_NORM || sq[SQRT_STEPS].op == OP_NORMZ) begin
      nr.ov = n_rnd[32] | n_rnd[31];
      nr.sc = nr.ov ? 32'h7FFF_FFFF : n_rnd[31:0];
      nr.dz = (sq[SQRT_STEPS].op == OP_NORMZ) && (n_rnd == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= nr;
    end
  end

  // ---------------- division: quotient bits FRAC_BITS down to 0 ----------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    qau_div_step #(.K(FRAC_BITS - k)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_vld[k]),
      .in_item   (dv[k]),
      .out_valid (dv_vld[k+1]),
      .out_item  (dv[k+1])
    );
  end

  // ---------------- output register ----------------
  logic [3:0][31:0] fin_r;
  logic             out_vld;
  logic [3:0][31:0] out_r;
  logic [31:0]      out_sc;
  logic             out_ov, out_dz;

  always_comb begin
    fin_r = dv[DIV_STEPS].r;
    if (dv[DIV_STEPS].op == OP_NORMZ) begin
      for (int i = 0; i < 4; i++) begin
        if (dv[DIV_STEPS].dz) begin
          fin_r[i] = '0;
        end else if (dv[DIV_STEPS].neg[i]) begin
          fin_r[i] = ~dv[DIV_STEPS].q[i] + 32'd1;
        end else begin
          fin_r[i] = dv[DIV_STEPS].q[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r  <= fin_r;
      out_sc <= dv[DIV_STEPS].sc;
      out_ov <= dv[DIV_STEPS].ov;
      out_dz <= dv[DIV_STEPS].dz;
    end
  end

  assign res.valid      = out_vld;
  assign res.r_w        = out_r[0];
  assign res.r_x        = out_r[1];
  assign res.r_y        = out_r[2];
  assign res.r_z        = out_r[3];
  assign res.scalar_out = out_sc;
  assign res.overflow   = out_ov;
  assign res.div_zero   = out_dz;

  // ---------------- assertions ----------------
  `QAU_ASSERT_IMPLIES(a_dz_clears, clk, rst, res.valid && res.div_zero, res.r_w == 32'd0 && res.r_x == 32'd0 && res.r_y == 32'd0 && res.r_z == 32'd0 && res.scalar_out == 32'd0)
  `QAU_ASSERT_NEVER(a_dz_no_ov, clk, rst, res.valid && res.div_zero && res.overflow)
  `QAU_ASSERT_NEXT(a_stall_holds, clk, rst, !en, $stable(sq_vld) && $stable(dv_vld) && $stable(s1_vld))

endmodule

// ===== tb/quaternion_arithmetic_unit_top_test.sv =====
// Self-checking testbench for quaternion_arithmetic_unit_top: random and directed items
// go in, and each result is compared with a built-in fixed-point quaternion predictor.
// Depends on qau_pkg, qau_intf and the DUT sources.
module quaternion_arithmetic_unit_top_test;
  import qau_pkg::*;

  localparam int unsigned FB = 16;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam logic [3:0] OP_SPARE = 4'd9;

  typedef logic signed [79:0] acc_t;

  typedef struct {
    bit          drain;  // hold the sender until all results are back
    logic [3:0]  op;
    logic [31:0] a[4];
    logic [31:0] b[4];
    logic [31:0] factor;
  } quat_cmd_t;

  typedef struct {
    logic [31:0] r[4];
    logic [31:0] sc;
    logic        ov;
    logic        dz;
  } quat_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  qau_cmd_if cmd ();
  qau_res_if res ();

  quaternion_arithmetic_unit_top #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .res(res.source)
  );

  always #6 clk = ~clk;

  quat_cmd_t pending_cmds[$];
  quat_res_t expected_res[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;   // no idling in the last part
  bit        sent = 1'b0;
  int        tx_idle = 0;
  int        rx_idle = 0;

  function automatic acc_t wide(input logic [31:0] v);
    return {{48{v[31]}}, v};
  endfunction

  function automatic logic [31:0] clamp32(input acc_t x, inout logic ov);
    if (x > acc_t'(MAX32)) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (x < acc_t'(MIN32)) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  // round half up after the fraction shift
  function automatic logic [31:0] fx_round(input acc_t s, inout logic ov);
    acc_t t;
    t = (s + (acc_t'(1) <<< (FB - 1))) >>> FB;
    return clamp32(t, ov);
  endfunction

  function automatic logic [63:0] root_round(input logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return (s > r) ? r + 1 : r;
  endfunction

  function automatic quat_res_t quat_compute(input quat_cmd_t c);
    quat_res_t   e;
    acc_t        a[4], b[4], t;
    logic [65:0] ssum;
    logic [63:0] n, m, q;
    for (int i = 0; i < 4; i++) begin
      a[i] = wide(c.a[i]);
      b[i] = wide(c.b[i]);
      e.r[i] = '0;
    end
    e.sc = '0;
    e.ov = 1'b0;
    e.dz = 1'b0;
    case (c.op)
      OP_ADD: for (int i = 0; i < 4; i++) e.r[i] = clamp32(a[i] + b[i], e.ov);
      OP_SUB: for (int i = 0; i < 4; i++) e.r[i] = clamp32(a[i] - b[i], e.ov);
      OP_PROD: begin
        e.r[0] = fx_round(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], e.ov);
        e.r[1] = fx_round(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], e.ov);
        e.r[2] = fx_round(a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3], e.ov);
        e.r[3] = fx_round(a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1], e.ov);
      end
      OP_SCALE: for (int i = 0; i < 4; i++) e.r[i] = fx_round(a[i] * wide(c.factor), e.ov);
      OP_CONJ: begin
        e.r[0] = c.a[0];
        for (int i = 1; i < 4; i++) e.r[i] = clamp32(-a[i], e.ov);
      end
      OP_NORM, OP_NORMZ: begin
        ssum = '0;
        for (int i = 0; i < 4; i++) begin
          m = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
          ssum = ssum + 66'(m * m);
        end
        if (ssum > 66'h0_FFFF_FFFF_FFFF_FFFF) ssum = 66'h0_FFFF_FFFF_FFFF_FFFF;
        if (ssum == 0) begin
          e.dz = (c.op == OP_NORMZ);
        end else begin
          n = root_round(ssum[63:0]);
          e.sc = clamp32(acc_t'(n), e.ov);
          if (c.op == OP_NORMZ)
            for (int i = 0; i < 4; i++) begin
              m = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
              q = ((m << FB) + (n >> 1)) / n;
              t = acc_t'(q);
              e.r[i] = clamp32((a[i] < 0) ? -t : t, e.ov);
            end
        end
      end
      OP_CROSS: begin
        e.r[1] = fx_round(a[2]*b[3] - a[3]*b[2], e.ov);
        e.r[2] = fx_round(a[3]*b[1] - a[1]*b[3], e.ov);
        e.r[3] = fx_round(a[1]*b[2] - a[2]*b[1], e.ov);
      end
      OP_DOT: e.sc = fx_round(a[1]*b[1] + a[2]*b[2] + a[3]*b[3], e.ov);
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [31:0] rand_word(input int mode);
    logic [31:0] w;
    case (mode)
      0: w = $urandom;
      1: w = $urandom_range(0, 1 << 19) - (1 << 18);
      default:
        case ($urandom_range(0, 5))
          0: w = 32'h7FFF_FFFF;
          1: w = 32'h8000_0000;
          2: w = 32'hFFFF_FFFF;
          3: w = 32'h0001_0000;
          4: w = 32'd1;
          default: w = 32'd0;
        endcase
    endcase
    return w;
  endfunction

  function automatic quat_cmd_t make_cmd(input logic [3:0] op, input int mode);
    quat_cmd_t c;
    c.drain = 1'b0;
    c.op = op;
    for (int i = 0; i < 4; i++) begin
      c.a[i] = rand_word(mode);
      c.b[i] = rand_word(mode);
    end
    c.factor = rand_word(mode);
    return c;
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      res.ready <= 1'b0;
    end else begin
      if (rx_idle > 0) begin
        rx_idle <= rx_idle - 1;
        res.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_idle <= $urandom_range(0, 7);
        res.ready <= 1'b0;
      end else res.ready <= 1'b1;

      if (!cmd.valid || sent) begin
        if (tx_idle > 0) begin
          tx_idle <= tx_idle - 1;
          cmd.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          tx_idle <= $urandom_range(0, 7);
          cmd.valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
          cmd.valid <= 1'b0;
          if (expected_res.size() == 0) void'(pending_cmds.pop_front());
        end else if (pending_cmds.size() > 0) begin
          quat_cmd_t c;
          c = pending_cmds.pop_front();
          cmd.valid  <= 1'b1;
          cmd.op     <= c.op;
          cmd.a_w    <= c.a[0];
          cmd.a_x    <= c.a[1];
          cmd.a_y    <= c.a[2];
          cmd.a_z    <= c.a[3];
          cmd.b_w    <= c.b[0];
          cmd.b_x    <= c.b[1];
          cmd.b_y    <= c.b[2];
          cmd.b_z    <= c.b[3];
          cmd.factor <= c.factor;
        end else cmd.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // monitor: accepted items are sampled on the rising edge
  always @(posedge clk) begin
    sent <= !rst && cmd.valid && cmd.ready;
    if (!rst) begin
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (cmd.valid && cmd.ready) begin
        quat_cmd_t c;
        c.drain = 1'b0;
        c.op = cmd.op;
        c.a = '{cmd.a_w, cmd.a_x, cmd.a_y, cmd.a_z};
        c.b = '{cmd.b_w, cmd.b_x, cmd.b_y, cmd.b_z};
        c.factor = cmd.factor;
        expected_res.push_back(quat_compute(c));
      end
      if (res.valid && res.ready) begin
        if (expected_res.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual w=%h x=%h y=%h z=%h", $time,
                   res.r_w, res.r_x, res.r_y, res.r_z);
        end else begin
          quat_res_t e;
          e = expected_res.pop_front();
          check_field("r_w", e.r[0], res.r_w);
          check_field("r_x", e.r[1], res.r_x);
          check_field("r_y", e.r[2], res.r_y);
          check_field("r_z", e.r[3], res.r_z);
          check_field("scalar_out", e.sc, res.scalar_out);
          check_field("overflow", 32'(e.ov), 32'(res.overflow));
          check_field("div_zero", 32'(e.dz), 32'(res.div_zero));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    quat_cmd_t c;
    cmd.valid = 1'b0;
    cmd.op = '0;
    cmd.a_w = '0; cmd.a_x = '0; cmd.a_y = '0; cmd.a_z = '0;
    cmd.b_w = '0; cmd.b_x = '0; cmd.b_y = '0; cmd.b_z = '0;
    cmd.factor = '0;
    res.ready = 1'b0;

    // directed: every op at the extremes, plus spare codes
    for (int k = 0; k < 16; k++) pending_cmds.push_back(make_cmd(4'(k), 2));
    c = make_cmd(OP_NORMZ, 2);
    c.a = '{32'd0, 32'd0, 32'd0, 32'd0};         // zero norm
    pending_cmds.push_back(c);
    c.op = OP_NORM;
    pending_cmds.push_back(c);
    c.a = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    pending_cmds.push_back(c);                   // norm past 32 bits
    c.op = OP_CONJ;                              // negate most negative
    pending_cmds.push_back(c);
    c.op = OP_NORMZ;
    pending_cmds.push_back(c);
    c = make_cmd(OP_PROD, 2);
    c.a = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    c.b = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    pending_cmds.push_back(c);
    c.op = OP_DOT;
    pending_cmds.push_back(c);
    c.op = OP_ADD;
    pending_cmds.push_back(c);
    c.drain = 1'b1;
    pending_cmds.push_back(c);

    for (int k = 0; k < 800; k++) begin
      logic [3:0] op;
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(OP_SPARE, 15))
                                        : 4'($urandom_range(0, 8));
      pending_cmds.push_back(make_cmd(op, ($urandom_range(0, 9) < 5) ? 1 :
                                          ($urandom_range(0, 4) == 0) ? 2 : 0));
      if (k == 400) begin
        c.drain = 1'b1;
        pending_cmds.push_back(c);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (pending_cmds.size() < 120);
    calm = 1'b1;
    wait (pending_cmds.size() == 0 && !cmd.valid && expected_res.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
